@@ hdl/masked_pixel_to_rgb888_unpack_assert.svh @@
// Assertion macros shared by the unpacker RTL.
// Both macros expect clk and rst_n in scope.
`ifndef MASKED_PIXEL_TO_RGB888_UNPACK_ASSERT_SVH
`define MASKED_PIXEL_TO_RGB888_UNPACK_ASSERT_SVH

// Same-cycle implication.
`define MPXU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mpxu: same-cycle check failed");

// Next-cycle implication.
`define MPXU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mpxu: next-cycle check failed");

`endif

@@ hdl/mpxu_pkg.sv @@
`default_nettype none

package mpxu_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_BPP        = 3'd0;
  localparam logic [2:0] REG_MSB_FIRST  = 3'd1;
  localparam logic [2:0] REG_RED_MASK   = 3'd2;
  localparam logic [2:0] REG_GREEN_MASK = 3'd3;
  localparam logic [2:0] REG_BLUE_MASK  = 3'd4;
  localparam logic [2:0] REG_ROW_PIXELS = 3'd5;
  localparam logic [2:0] REG_ROW_STRIDE = 3'd6;
  localparam logic [2:0] REG_ROW_COUNT  = 3'd7;

  // Register reset values
  localparam logic [2:0]  RST_BPP        = 3'd4;
  localparam logic        RST_MSB_FIRST  = 1'b0;
  localparam logic [31:0] RST_RED_MASK   = 32'h00FF_0000;
  localparam logic [31:0] RST_GREEN_MASK = 32'h0000_FF00;
  localparam logic [31:0] RST_BLUE_MASK  = 32'h0000_00FF;
  localparam logic [12:0] RST_ROW_PIXELS = 13'd640;
  localparam logic [14:0] RST_ROW_STRIDE = 15'd2560;
  localparam logic [12:0] RST_ROW_COUNT  = 13'd480;

  // Largest row count per frame
  localparam logic [12:0] MAX_ROWS = 13'd4096;

  // Color channel codes for the shared scaler
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // Framing configuration seen by the byte assembler
  typedef struct packed {
    logic [2:0]  bpp;
    logic        msb_first;
    logic [12:0] row_pixels;
    logic [14:0] row_stride;
    logic [12:0] row_count;
  } cfg_t;

  // Marks that travel with a completed pixel
  typedef struct packed {
    logic row_end;
    logic frame_end;
  } mark_t;

endpackage

`default_nettype wire

@@ hdl/mpxu_scale.sv @@
`default_nettype none

// Shared channel scaler: q = floor((510*v + m) / (2*m)), v = word & mask.
// One restoring quotient bit per cycle; a zero mask gives 0.
module mpxu_scale (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] word,
  input  wire logic [31:0] mask,
  output logic             done,
  output logic [7:0]       q
);

  localparam logic [1:0] SC_IDLE = 2'd0;
  localparam logic [1:0] SC_MUL  = 2'd1;
  localparam logic [1:0] SC_ADD  = 2'd2;
  localparam logic [1:0] SC_DIV  = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [31:0] val_r;
  logic [31:0] msk_r;
  logic [40:0] rem_r;
  logic [39:0] dvs_r;
  logic [7:0]  q_r;
  logic        ge;

  assign ge = rem_r >= {1'b0, dvs_r};

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      SC_IDLE: if (start) state_nxt = SC_MUL;
      SC_MUL:  state_nxt = SC_ADD;
      SC_ADD: begin
        state_nxt = SC_DIV;
        cnt_nxt   = 3'd0;
      end
      SC_DIV: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          state_nxt = SC_IDLE;
          done_nxt  = 1'b1;
        end
      end
      default: state_nxt = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
      cnt_r   <= 3'd0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  // Datapath: latch operands, form 510*v by shift-subtract, add m, divide
  always_ff @(posedge clk) begin
    unique case (state_r)
      SC_IDLE: begin
        if (start) begin
          val_r <= word & mask;
          msk_r <= mask;
        end
      end
      SC_MUL: begin
        rem_r <= ({9'd0, val_r} << 9) - ({9'd0, val_r} << 1);
      end
      SC_ADD: begin
        rem_r <= rem_r + {9'd0, msk_r};
        dvs_r <= {msk_r, 8'd0};
      end
      SC_DIV: begin
        if (ge) rem_r <= rem_r - {1'b0, dvs_r};
        dvs_r <= dvs_r >> 1;
        q_r   <= {q_r[6:0], ge};
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign q    = (msk_r == 32'd0) ? 8'd0 : q_r;

endmodule

`default_nettype wire

@@ hdl/mpxu_frame.sv @@
`default_nettype none

// Byte assembler and row/frame counters. Flags the byte that completes a pixel.
module mpxu_frame #(
  parameter int MAX_ROW_PIXELS = 4096,
  parameter int MAX_ROW_STRIDE = 16384
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           accept,
  input  wire logic [7:0]     image_byte,
  input  wire mpxu_pkg::cfg_t cfg,
  output logic                pix_last,
  output logic [31:0]         word,
  output mpxu_pkg::mark_t     mark
);

  logic [31:0] word_r, word_nxt;
  logic [1:0]  bip_r, bip_nxt;
  logic [13:0] bir_r, bir_nxt;
  logic [11:0] pir_r, pir_nxt;
  logic [11:0] ri_r, ri_nxt;
  mpxu_pkg::mark_t mark_r, mark_nxt;

  logic [2:0]  bpp_c;
  logic [12:0] rp_c;
  logic [14:0] rs_c;
  logic [12:0] rc_c;
  logic        pad;
  logic [14:0] bir_inc;
  logic        row_wrap;
  logic        last_row;
  logic        row_last_pix;
  logic [31:0] base;
  logic [31:0] assembled;

  // Clamp configuration to legal ranges
  always_comb begin
    if (cfg.bpp == 3'd0)      bpp_c = 3'd1;
    else if (cfg.bpp > 3'd4)  bpp_c = 3'd4;
    else                      bpp_c = cfg.bpp;

    if (cfg.row_pixels == 13'd0)                            rp_c = 13'd1;
    else if ({19'd0, cfg.row_pixels} > 32'(MAX_ROW_PIXELS)) rp_c = 13'(MAX_ROW_PIXELS);
    else                                                    rp_c = cfg.row_pixels;

    if ({17'd0, cfg.row_stride} > 32'(MAX_ROW_STRIDE)) rs_c = 15'(MAX_ROW_STRIDE);
    else                                               rs_c = cfg.row_stride;

    if (cfg.row_count == 13'd0)                rc_c = 13'd1;
    else if (cfg.row_count > mpxu_pkg::MAX_ROWS) rc_c = mpxu_pkg::MAX_ROWS;
    else                                       rc_c = cfg.row_count;
  end

  // Position tests
  assign pad          = {1'b0, pir_r} >= rp_c;
  assign bir_inc      = {1'b0, bir_r} + 15'd1;
  assign row_wrap     = bir_inc >= rs_c;
  assign last_row     = ({1'b0, ri_r} + 13'd1) >= rc_c;
  assign row_last_pix = ({1'b0, pir_r} + 13'd1) >= rp_c;
  assign pix_last     = !pad && (({1'b0, bip_r} + 3'd1) >= bpp_c);

  // Merge the byte into the pixel word
  always_comb begin
    base = (bip_r == 2'd0) ? 32'd0 : word_r;
    if (cfg.msb_first) assembled = {base[23:0], image_byte};
    else               assembled = base | ({24'd0, image_byte} << {bip_r, 3'b000});
  end

  // Advance counters on each transfer
  always_comb begin
    word_nxt = word_r;
    bip_nxt  = bip_r;
    bir_nxt  = bir_r;
    pir_nxt  = pir_r;
    ri_nxt   = ri_r;
    mark_nxt = mark_r;
    if (accept) begin
      if (pad) begin
        if (row_wrap) begin
          bir_nxt = 14'd0;
          pir_nxt = 12'd0;
          bip_nxt = 2'd0;
          ri_nxt  = last_row ? 12'd0 : ri_r + 12'd1;
        end else begin
          bir_nxt = bir_inc[13:0];
        end
      end else begin
        word_nxt = assembled;
        if (!pix_last) begin
          bip_nxt = bip_r + 2'd1;
          bir_nxt = bir_inc[13:0];
        end else begin
          bip_nxt            = 2'd0;
          mark_nxt.row_end   = row_last_pix;
          mark_nxt.frame_end = row_last_pix && last_row;
          if (row_last_pix) begin
            if (row_wrap) begin
              bir_nxt = 14'd0;
              pir_nxt = 12'd0;
              ri_nxt  = last_row ? 12'd0 : ri_r + 12'd1;
            end else begin
              // a row of 4096 pixels leaves the counter parked at its top
              pir_nxt = rp_c[12] ? 12'hFFF : rp_c[11:0];
              bir_nxt = bir_inc[13:0];
            end
          end else begin
            pir_nxt = pir_r + 12'd1;
            bir_nxt = bir_inc[13:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bip_r <= 2'd0;
      bir_r <= 14'd0;
      pir_r <= 12'd0;
      ri_r  <= 12'd0;
    end else begin
      bip_r <= bip_nxt;
      bir_r <= bir_nxt;
      pir_r <= pir_nxt;
      ri_r  <= ri_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    mark_r <= mark_nxt;
  end

  assign word = word_r;
  assign mark = mark_r;

endmodule

`default_nettype wire

@@ hdl/masked_pixel_to_rgb888_unpack.sv @@
`default_nettype none

// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  in_image_byte
// out      output     out_valid/out_stall out_red, out_green, out_blue,
//                                         out_row_end, out_frame_end
// cfg      input      psel/penable/pready paddr, pwdata, prdata
//
// A byte that does not complete a pixel raises no stall.
// A pixel-completing byte holds in_stall high while the shared scaler works
// through the three channels in turn and the result is loaded into the output register.
// The result sits in an output register, so the next bytes flow while it waits.
// Reset (rst_n, synchronous) restores register defaults and clears counters.
// out_stall holds the output register and delays the hand-over of a finished pixel to it.
module masked_pixel_to_rgb888_unpack #(
  parameter int MAX_ROW_PIXELS = 4096,
  parameter int MAX_ROW_STRIDE = 16384
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_image_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic             out_row_end,
  output logic             out_frame_end,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_RUN  = 2'd1;
  localparam logic [1:0] T_HOLD = 2'd2;

  // Configuration registers
  logic [2:0]  bpp_r;
  logic        msb_first_r;
  logic [31:0] red_mask_r;
  logic [31:0] green_mask_r;
  logic [31:0] blue_mask_r;
  logic [12:0] row_pixels_r;
  logic [14:0] row_stride_r;
  logic [12:0] row_count_r;

  logic [1:0]  state_r, state_nxt;
  logic [1:0]  ch_r, ch_nxt;
  logic        start_r, start_nxt;
  logic [7:0]  red_s_r, green_s_r, blue_s_r;
  logic        out_valid_r;
  logic [7:0]  out_red_r, out_green_r, out_blue_r;
  mpxu_pkg::mark_t out_mark_r;

  logic            accept_in;
  logic            pix_last;
  logic [31:0]     pix_word;
  mpxu_pkg::mark_t pix_mark;
  mpxu_pkg::cfg_t  cfg;
  logic [31:0]     scale_mask;
  logic            scale_done;
  logic [7:0]      scale_q;
  logic            out_free;
  logic            load_out;
  logic            cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r        <= mpxu_pkg::RST_BPP;
      msb_first_r  <= mpxu_pkg::RST_MSB_FIRST;
      red_mask_r   <= mpxu_pkg::RST_RED_MASK;
      green_mask_r <= mpxu_pkg::RST_GREEN_MASK;
      blue_mask_r  <= mpxu_pkg::RST_BLUE_MASK;
      row_pixels_r <= mpxu_pkg::RST_ROW_PIXELS;
      row_stride_r <= mpxu_pkg::RST_ROW_STRIDE;
      row_count_r  <= mpxu_pkg::RST_ROW_COUNT;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        mpxu_pkg::REG_BPP:        bpp_r        <= pwdata[2:0];
        mpxu_pkg::REG_MSB_FIRST:  msb_first_r  <= pwdata[0];
        mpxu_pkg::REG_RED_MASK:   red_mask_r   <= pwdata;
        mpxu_pkg::REG_GREEN_MASK: green_mask_r <= pwdata;
        mpxu_pkg::REG_BLUE_MASK:  blue_mask_r  <= pwdata;
        mpxu_pkg::REG_ROW_PIXELS: row_pixels_r <= pwdata[12:0];
        mpxu_pkg::REG_ROW_STRIDE: row_stride_r <= pwdata[14:0];
        mpxu_pkg::REG_ROW_COUNT:  row_count_r  <= pwdata[12:0];
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[4:2])
      mpxu_pkg::REG_BPP:        prdata = {29'd0, bpp_r};
      mpxu_pkg::REG_MSB_FIRST:  prdata = {31'd0, msb_first_r};
      mpxu_pkg::REG_RED_MASK:   prdata = red_mask_r;
      mpxu_pkg::REG_GREEN_MASK: prdata = green_mask_r;
      mpxu_pkg::REG_BLUE_MASK:  prdata = blue_mask_r;
      mpxu_pkg::REG_ROW_PIXELS: prdata = {19'd0, row_pixels_r};
      mpxu_pkg::REG_ROW_STRIDE: prdata = {17'd0, row_stride_r};
      mpxu_pkg::REG_ROW_COUNT:  prdata = {19'd0, row_count_r};
    endcase
  end

  assign cfg.bpp        = bpp_r;
  assign cfg.msb_first  = msb_first_r;
  assign cfg.row_pixels = row_pixels_r;
  assign cfg.row_stride = row_stride_r;
  assign cfg.row_count  = row_count_r;

  assign in_stall  = (state_r != T_IDLE);
  assign accept_in = in_valid && !in_stall;

  mpxu_frame #(
    .MAX_ROW_PIXELS (MAX_ROW_PIXELS),
    .MAX_ROW_STRIDE (MAX_ROW_STRIDE)
  ) u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept_in),
    .image_byte (in_image_byte),
    .cfg        (cfg),
    .pix_last   (pix_last),
    .word       (pix_word),
    .mark       (pix_mark)
  );

  // Pick the mask for the channel in progress
  always_comb begin
    unique case (ch_r)
      mpxu_pkg::CH_RED:   scale_mask = red_mask_r;
      mpxu_pkg::CH_GREEN: scale_mask = green_mask_r;
      default:            scale_mask = blue_mask_r;
    endcase
  end

  mpxu_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .word  (pix_word),
    .mask  (scale_mask),
    .done  (scale_done),
    .q     (scale_q)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign load_out = (state_r == T_HOLD) && out_free;

  // Sequence the three channels through the scaler
  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    start_nxt = 1'b0;
    unique case (state_r)
      T_IDLE: begin
        if (accept_in && pix_last) begin
          state_nxt = T_RUN;
          ch_nxt    = mpxu_pkg::CH_RED;
          start_nxt = 1'b1;
        end
      end
      T_RUN: begin
        if (scale_done) begin
          if (ch_r == mpxu_pkg::CH_BLUE) begin
            state_nxt = T_HOLD;
          end else begin
            ch_nxt    = ch_r + 2'd1;
            start_nxt = 1'b1;
          end
        end
      end
      T_HOLD: begin
        if (out_free) state_nxt = T_IDLE;
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      ch_r    <= mpxu_pkg::CH_RED;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      start_r <= start_nxt;
    end
  end

  // Collect channel results
  always_ff @(posedge clk) begin
    if (scale_done) begin
      unique case (ch_r)
        mpxu_pkg::CH_RED:   red_s_r   <= scale_q;
        mpxu_pkg::CH_GREEN: green_s_r <= scale_q;
        default:            blue_s_r  <= scale_q;
      endcase
    end
  end

  // Output register: load when free, drop valid after the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_red_r   <= red_s_r;
      out_green_r <= green_s_r;
      out_blue_r  <= blue_s_r;
      out_mark_r  <= pix_mark;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = out_red_r;
  assign out_green     = out_green_r;
  assign out_blue      = out_blue_r;
  assign out_row_end   = out_mark_r.row_end;
  assign out_frame_end = out_mark_r.frame_end;

`include "masked_pixel_to_rgb888_unpack_assert.svh"

  `MPXU_ASSERT_NXT(a_stall_after_pixel, accept_in && pix_last, in_stall)
  `MPXU_ASSERT_IMP(a_done_only_running, scale_done, state_r == T_RUN)
  `MPXU_ASSERT_IMP(a_zero_mask_zero, scale_done && (scale_mask == 32'd0), scale_q == 8'd0)

endmodule

`default_nettype wire
